FILE: rtl/assert_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define R2N_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define R2N_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/r2n_pkg.sv
// Shared types, constants and coefficients of the RGB to NV12 converter.
package r2n_pkg;

  localparam int MAX_WIDTH      = 4096;
  localparam int COEF_FRAC_BITS = 16;
  localparam int HEIGHT_LIMIT   = 4096;

  localparam int SIZE_W     = 13;
  localparam int POS_W      = 12;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int SUM_W      = 9;
  localparam int LINE_W     = 3 * SUM_W;
  localparam int CFG_IDX_W  = 1;

  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int QCNT_W     = QAW + 1;
  localparam int OBUF_DEPTH = 4;
  localparam int OBAW       = $clog2(OBUF_DEPTH);
  localparam int OBCNT_W    = OBAW + 1;

  // All coefficients are below one, so they fit in the fraction bits.
  localparam int COEF_W = COEF_FRAC_BITS;
  localparam int PROD_W = COEF_W + 8;
  localparam int ACC_W  = COEF_FRAC_BITS + 10;

  localparam logic [COEF_W-1:0] C_Y_R  = COEF_W'((64'(1826) << COEF_FRAC_BITS) / 10000);
  localparam logic [COEF_W-1:0] C_Y_G  = COEF_W'((64'(6142) << COEF_FRAC_BITS) / 10000);
  localparam logic [COEF_W-1:0] C_Y_B  = COEF_W'((64'(620) << COEF_FRAC_BITS) / 10000);
  localparam logic [COEF_W-1:0] C_CB_R = COEF_W'((64'(1006) << COEF_FRAC_BITS) / 10000);
  localparam logic [COEF_W-1:0] C_CB_G = COEF_W'((64'(3386) << COEF_FRAC_BITS) / 10000);
  localparam logic [COEF_W-1:0] C_CB_B = COEF_W'((64'(4392) << COEF_FRAC_BITS) / 10000);
  localparam logic [COEF_W-1:0] C_CR_R = COEF_W'((64'(4392) << COEF_FRAC_BITS) / 10000);
  localparam logic [COEF_W-1:0] C_CR_G = COEF_W'((64'(3989) << COEF_FRAC_BITS) / 10000);
  localparam logic [COEF_W-1:0] C_CR_B = COEF_W'((64'(403) << COEF_FRAC_BITS) / 10000);

  localparam logic signed [ACC_W-1:0] OFS_LUMA   = ACC_W'(64'(16) << COEF_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] OFS_CHROMA = ACC_W'(64'(128) << COEF_FRAC_BITS);

  localparam logic [7:0] LUMA_LO        = 8'd16;
  localparam logic [7:0] LUMA_HI        = 8'd235;
  localparam logic [7:0] CHROMA_LO      = 8'd16;
  localparam logic [7:0] CHROMA_HI      = 8'd240;
  localparam logic [7:0] CHROMA_NEUTRAL = 8'd128;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1280);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(720);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } r2n_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } r2n_in_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       frame_end;
  } r2n_out_t;

  // One classified pixel handed from the front to the back.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
    logic       chroma_valid;
    logic       frame_end;
  } r2n_work_t;

  typedef struct packed {
    logic [QCNT_W-1:0] level;
    logic              empty;
  } r2n_qstat_t;

endpackage

FILE: rtl/r2n_front.sv
// Front end: size registers, raster position, pair sums and the even-row line store.
`include "assert_macros.svh"

module r2n_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  r2n_pkg::r2n_reg_t              cfg_index,
  input  logic [r2n_pkg::SIZE_W-1:0]     cfg_wdata,
  input  logic                           in_push,
  input  r2n_pkg::r2n_in_t               in_data,
  output logic                           in_full,
  input  r2n_pkg::r2n_qstat_t            qstat,
  output logic                           q_push,
  output r2n_pkg::r2n_work_t             q_data
);
  import r2n_pkg::*;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_blue;
    logic             chroma_valid;
    logic             frame_end;
  } s1_t;

  logic [SIZE_W-1:0] width_r, height_r;
  logic [POS_W-1:0]  col_r, row_r, col_nxt, row_nxt;
  logic [23:0]       left_r;
  logic              s1_valid_r;
  s1_t               s1_r;
  logic [LINE_W-1:0] line_mem [LINE_DEPTH];
  logic [LINE_W-1:0] line_q_r;

  logic              accept;
  logic [POS_W-1:0]  col_cur, row_cur, col_half;
  logic [SIZE_W-1:0] w_eff, h_eff, col_inc, row_inc;
  logic              row_end, frame_end_c;
  logic [SUM_W-1:0]  sum_red, sum_green, sum_blue;
  logic [LINE_AW-1:0] line_idx;
  logic              line_we, line_re;
  logic [SUM_W:0]    tot_red, tot_green, tot_blue;

  assign in_full = (qstat.level + QCNT_W'(s1_valid_r)) >= QCNT_W'(QDEPTH);
  assign accept  = in_push && !in_full;

  always_comb begin
    col_cur = in_data.frame_start ? '0 : col_r;
    row_cur = in_data.frame_start ? '0 : row_r;

    if (width_r == '0) begin
      w_eff = SIZE_W'(1);
    end else if (width_r > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = SIZE_W'(1);
    end else if (height_r > SIZE_W'(HEIGHT_LIMIT)) begin
      h_eff = SIZE_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = height_r;
    end

    col_inc     = {1'b0, col_cur} + SIZE_W'(1);
    row_inc     = {1'b0, row_cur} + SIZE_W'(1);
    row_end     = col_inc >= w_eff;
    frame_end_c = row_end && (row_inc >= h_eff);

    col_nxt = row_end ? '0 : col_inc[POS_W-1:0];
    if (!row_end) begin
      row_nxt = row_cur;
    end else if (frame_end_c) begin
      row_nxt = '0;
    end else begin
      row_nxt = row_inc[POS_W-1:0];
    end

    sum_red   = {1'b0, left_r[23:16]} + {1'b0, in_data.red};
    sum_green = {1'b0, left_r[15:8]} + {1'b0, in_data.green};
    sum_blue  = {1'b0, left_r[7:0]} + {1'b0, in_data.blue};

    col_half = col_cur >> 1;
    if ({1'b0, col_half} >= (POS_W + 1)'(LINE_DEPTH)) begin
      line_idx = LINE_AW'(LINE_DEPTH - 1);
    end else begin
      line_idx = LINE_AW'(col_half);
    end

    // Right pixel of a pair: even rows store the sums, odd rows fetch them.
    line_we = accept && col_cur[0] && !row_cur[0];
    line_re = accept && col_cur[0] && row_cur[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RESET;
      height_r   <= HEIGHT_RESET;
      col_r      <= '0;
      row_r      <= '0;
      left_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_r  <= cfg_wdata;
          REG_FRAME_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        left_r <= {in_data.red, in_data.green, in_data.blue};
      end
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.red          <= in_data.red;
      s1_r.green        <= in_data.green;
      s1_r.blue         <= in_data.blue;
      s1_r.sum_red      <= sum_red;
      s1_r.sum_green    <= sum_green;
      s1_r.sum_blue     <= sum_blue;
      s1_r.chroma_valid <= col_cur[0] && row_cur[0];
      s1_r.frame_end    <= frame_end_c;
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_idx] <= {sum_red, sum_green, sum_blue};
    end
    if (line_re) begin
      line_q_r <= line_mem[line_idx];
    end
  end

  // Block average: four-pixel sum divided by four, truncated.
  always_comb begin
    tot_red   = {1'b0, s1_r.sum_red} + {1'b0, line_q_r[3*SUM_W-1:2*SUM_W]};
    tot_green = {1'b0, s1_r.sum_green} + {1'b0, line_q_r[2*SUM_W-1:SUM_W]};
    tot_blue  = {1'b0, s1_r.sum_blue} + {1'b0, line_q_r[SUM_W-1:0]};

    q_data.red          = s1_r.red;
    q_data.green        = s1_r.green;
    q_data.blue         = s1_r.blue;
    q_data.avg_red      = tot_red[SUM_W:2];
    q_data.avg_green    = tot_green[SUM_W:2];
    q_data.avg_blue     = tot_blue[SUM_W:2];
    q_data.chroma_valid = s1_r.chroma_valid;
    q_data.frame_end    = s1_r.frame_end;
  end

  assign q_push = s1_valid_r;

  `R2N_ASSERT(a_frame_wrap, (accept && frame_end_c) |=> (col_r == '0 && row_r == '0), "position not cleared after frame end")

endmodule

FILE: rtl/r2n_queue.sv
// Short queue of classified pixels between the front and the back.
`include "assert_macros.svh"

module r2n_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_push,
  input  r2n_pkg::r2n_work_t   q_wdata,
  input  logic                 q_pop,
  output r2n_pkg::r2n_work_t   q_rdata,
  output r2n_pkg::r2n_qstat_t  qstat
);
  import r2n_pkg::*;

  r2n_work_t         slot_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_r + QCNT_W'(q_push) - QCNT_W'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      slot_r[wr_ptr_r] <= q_wdata;
    end
  end

  assign q_rdata     = slot_r[rd_ptr_r];
  assign qstat.level = count_r;
  assign qstat.empty = (count_r == '0);

  `R2N_NEVER(a_q_overflow, q_push && !q_pop && count_r == QCNT_W'(QDEPTH), "work queue overflow")
  `R2N_NEVER(a_q_underflow, q_pop && count_r == '0, "work queue underflow")

endmodule

FILE: rtl/r2n_back.sv
// Back end: luma and chroma arithmetic, clamping and the result buffer.
`include "assert_macros.svh"

module r2n_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  r2n_pkg::r2n_work_t   q_data,
  input  r2n_pkg::r2n_qstat_t  qstat,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output r2n_pkg::r2n_out_t    out_data
);
  import r2n_pkg::*;

  function automatic logic [7:0] clamp_scaled(input logic signed [ACC_W-1:0] acc,
                                              input logic [7:0] lo,
                                              input logic [7:0] hi);
    logic signed [ACC_W-1:0]          lo_s;
    logic [ACC_W-COEF_FRAC_BITS-1:0]  v;
    lo_s = signed'(ACC_W'(lo) << COEF_FRAC_BITS);
    v    = acc[ACC_W-1:COEF_FRAC_BITS];
    if (acc <= lo_s) begin
      return lo;
    end else if (v > (ACC_W - COEF_FRAC_BITS)'(hi)) begin
      return hi;
    end else begin
      return v[7:0];
    end
  endfunction

  logic              a_valid_r, a_chroma_r, a_fend_r;
  logic [PROD_W-1:0] py_r [3];
  logic [PROD_W-1:0] pcb_r [3];
  logic [PROD_W-1:0] pcr_r [3];

  logic signed [ACC_W-1:0] acc_y, acc_cb, acc_cr;
  r2n_out_t                res;

  r2n_out_t           ob_r [OBUF_DEPTH];
  logic [OBAW-1:0]    ob_wr_r, ob_rd_r;
  logic [OBCNT_W-1:0] ob_cnt_r;
  logic               ob_pop;

  // Pull only when the buffer can take every result still in flight.
  assign q_pop  = !qstat.empty && ((ob_cnt_r + OBCNT_W'(a_valid_r)) < OBCNT_W'(OBUF_DEPTH));
  assign ob_pop = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      py_r[0]    <= PROD_W'(C_Y_R) * PROD_W'(q_data.red);
      py_r[1]    <= PROD_W'(C_Y_G) * PROD_W'(q_data.green);
      py_r[2]    <= PROD_W'(C_Y_B) * PROD_W'(q_data.blue);
      pcb_r[0]   <= PROD_W'(C_CB_R) * PROD_W'(q_data.avg_red);
      pcb_r[1]   <= PROD_W'(C_CB_G) * PROD_W'(q_data.avg_green);
      pcb_r[2]   <= PROD_W'(C_CB_B) * PROD_W'(q_data.avg_blue);
      pcr_r[0]   <= PROD_W'(C_CR_R) * PROD_W'(q_data.avg_red);
      pcr_r[1]   <= PROD_W'(C_CR_G) * PROD_W'(q_data.avg_green);
      pcr_r[2]   <= PROD_W'(C_CR_B) * PROD_W'(q_data.avg_blue);
      a_chroma_r <= q_data.chroma_valid;
      a_fend_r   <= q_data.frame_end;
    end
  end

  always_comb begin
    acc_y  = OFS_LUMA + signed'(ACC_W'(py_r[0])) + signed'(ACC_W'(py_r[1]))
           + signed'(ACC_W'(py_r[2]));
    acc_cb = OFS_CHROMA - signed'(ACC_W'(pcb_r[0])) - signed'(ACC_W'(pcb_r[1]))
           + signed'(ACC_W'(pcb_r[2]));
    acc_cr = OFS_CHROMA + signed'(ACC_W'(pcr_r[0])) - signed'(ACC_W'(pcr_r[1]))
           - signed'(ACC_W'(pcr_r[2]));

    res.luma         = clamp_scaled(acc_y, LUMA_LO, LUMA_HI);
    res.chroma_valid = a_chroma_r;
    res.cb           = a_chroma_r ? clamp_scaled(acc_cb, CHROMA_LO, CHROMA_HI) : CHROMA_NEUTRAL;
    res.cr           = a_chroma_r ? clamp_scaled(acc_cr, CHROMA_LO, CHROMA_HI) : CHROMA_NEUTRAL;
    res.frame_end    = a_fend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= '0;
      ob_rd_r  <= '0;
      ob_cnt_r <= '0;
    end else begin
      if (a_valid_r) begin
        ob_wr_r <= ob_wr_r + OBAW'(1);
      end
      if (ob_pop) begin
        ob_rd_r <= ob_rd_r + OBAW'(1);
      end
      ob_cnt_r <= ob_cnt_r + OBCNT_W'(a_valid_r) - OBCNT_W'(ob_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r) begin
      ob_r[ob_wr_r] <= res;
    end
  end

  assign out_empty = (ob_cnt_r == '0);
  assign out_data  = ob_r[ob_rd_r];

  `R2N_NEVER(a_ob_overflow, a_valid_r && ob_cnt_r == OBCNT_W'(OBUF_DEPTH), "result buffer overflow")
  `R2N_ASSERT(a_pop_to_stage, q_pop |=> a_valid_r, "popped transaction lost before arithmetic")

endmodule

FILE: rtl/rgb_to_nv12_converter_unit.sv
// Top level of the streaming BT.709 RGB to YCbCr 4:2:0 (NV12 order) converter.
// Throughput: one transaction per cycle each way unless in_full or out_empty
// holds it; the single-port line store takes one write (even row) or one read
// (odd row) per pixel pair, so it never stalls.
// Reset (synchronous, rst_n low): position, left pixel and queues clear,
// frame_width = 1280, frame_height = 720; the line store is not cleared.
module rgb_to_nv12_converter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  r2n_pkg::r2n_reg_t              cfg_index,
  input  logic [r2n_pkg::SIZE_W-1:0]     cfg_wdata,
  input  logic                           in_push,
  input  r2n_pkg::r2n_in_t               in_data,
  output logic                           in_full,
  output logic                           out_empty,
  input  logic                           out_pop,
  output r2n_pkg::r2n_out_t              out_data
);
  import r2n_pkg::*;

  // Front -> queue -> back. The front reserves a queue slot for its
  // registered stage, so the line-store read data is never dropped.
  logic       q_push, q_pop;
  r2n_work_t  q_wdata, q_rdata;
  r2n_qstat_t qstat;

  // Classifies each pixel by raster position and builds block averages.
  r2n_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .qstat     (qstat),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // Four-entry decoupling queue; each side stalls on its own.
  r2n_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .qstat   (qstat)
  );

  // Constant-coefficient products, then sum, clamp and buffer the result.
  r2n_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_rdata),
    .qstat     (qstat),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

FILE: tb/rgb_to_nv12_converter_unit_tb.sv
// Self-checking testbench for the streaming RGB to BT.709 NV12 converter unit.
module rgb_to_nv12_converter_unit_tb;
  import r2n_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int PIPE_LATENCY   = 3;     // extra idle margin for drain_pipeline
  localparam int HOLD_CYCLES    = 300;   // long output hold-off for the fill-up test
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before the run is declared hung
  localparam int MAX_PRINTED    = 20;    // mismatch lines printed, the rest only counted
  localparam int FRAC           = COEF_FRAC_BITS;

  // Q16 coefficients, floored from the four-decimal BT.709 values.
  localparam longint K_Y_R  = (longint'(1826) << FRAC) / 10000;
  localparam longint K_Y_G  = (longint'(6142) << FRAC) / 10000;
  localparam longint K_Y_B  = (longint'(620) << FRAC) / 10000;
  localparam longint K_CB_R = (longint'(1006) << FRAC) / 10000;
  localparam longint K_CB_G = (longint'(3386) << FRAC) / 10000;
  localparam longint K_CB_B = (longint'(4392) << FRAC) / 10000;
  localparam longint K_CR_R = (longint'(4392) << FRAC) / 10000;
  localparam longint K_CR_G = (longint'(3989) << FRAC) / 10000;
  localparam longint K_CR_B = (longint'(403) << FRAC) / 10000;

  // DUT ports, inputs all known from time zero
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  r2n_reg_t          cfg_index = REG_FRAME_WIDTH;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  logic              in_push   = 1'b0;
  r2n_in_t           in_data   = '0;
  logic              in_full;
  logic              out_empty;
  logic              out_pop   = 1'b0;
  r2n_out_t          out_data;

  // Predictor state: mirrors the converter's registers and line store.
  logic [SIZE_W-1:0] frame_width_q  = WIDTH_RESET;
  logic [SIZE_W-1:0] frame_height_q = HEIGHT_RESET;
  int unsigned       col_pos        = 0;
  int unsigned       row_pos        = 0;
  logic [23:0]       left_rgb       = '0;
  logic [LINE_W-1:0] pair_sums    [LINE_DEPTH];
  bit                pair_written [LINE_DEPTH];

  // Expected converter output, oldest first, one entry per accepted pixel.
  r2n_out_t pending_pixels [$];

  // Flow control knobs shared between the tests and the receiver.
  bit calm     = 1'b0;   // no idling on either side while set, but for the hold-off
  bit hold_req = 1'b0;   // one-shot request for the long output hold-off
  int hold_left = 0;

  int unsigned pixels_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned chroma_blocks   = 0;
  int unsigned frames_closed   = 0;
  int unsigned mismatch_count  = 0;
  int unsigned quiet_cycles    = 0;

  rgb_to_nv12_converter_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Floor a Q16 sum to an integer and clamp it; at or below the low bound
  // counts as the low bound.
  function automatic logic [7:0] scaled_clamp(input longint acc, input logic [7:0] lo,
                                              input logic [7:0] hi);
    longint v;
    if (acc <= (longint'(lo) << FRAC)) return lo;
    v = acc >>> FRAC;
    if (v > longint'(hi)) return hi;
    return v[7:0];
  endfunction

  // Expected transaction for one accepted pixel; advances the predictor state.
  function automatic r2n_out_t convert_pixel(input r2n_in_t px);
    r2n_out_t          res;
    int unsigned       w;
    int unsigned       h;
    int unsigned       idx;
    logic [8:0]        sum_r;
    logic [8:0]        sum_g;
    logic [8:0]        sum_b;
    logic [LINE_W-1:0] upper;
    longint            r;
    longint            g;
    longint            b;
    longint            avg_r;
    longint            avg_g;
    longint            avg_b;

    // zero acts as one, oversize saturates
    w = (frame_width_q == 0) ? 1 : frame_width_q;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (frame_height_q == 0) ? 1 : frame_height_q;
    if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;

    r = px.red;
    g = px.green;
    b = px.blue;
    res = '0;
    res.cb = CHROMA_NEUTRAL;
    res.cr = CHROMA_NEUTRAL;
    res.luma = scaled_clamp((longint'(16) << FRAC) + K_Y_R * r + K_Y_G * g + K_Y_B * b,
                            LUMA_LO, LUMA_HI);

    if (px.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end

    // odd column closes a horizontal pair: even rows store it, odd rows finish the block
    if (col_pos[0]) begin
      sum_r = left_rgb[23:16] + px.red;
      sum_g = left_rgb[15:8] + px.green;
      sum_b = left_rgb[7:0] + px.blue;
      idx = col_pos >> 1;
      if (idx >= LINE_DEPTH) idx = LINE_DEPTH - 1;
      if (!row_pos[0]) begin
        pair_sums[idx] = {sum_r, sum_g, sum_b};
        pair_written[idx] = 1'b1;
      end else begin
        upper = pair_sums[idx];
        avg_r = (sum_r + upper[26:18]) >> 2;
        avg_g = (sum_g + upper[17:9]) >> 2;
        avg_b = (sum_b + upper[8:0]) >> 2;
        res.cb = scaled_clamp((longint'(128) << FRAC) - K_CB_R * avg_r - K_CB_G * avg_g
                              + K_CB_B * avg_b, CHROMA_LO, CHROMA_HI);
        res.cr = scaled_clamp((longint'(128) << FRAC) + K_CR_R * avg_r - K_CR_G * avg_g
                              - K_CR_B * avg_b, CHROMA_LO, CHROMA_HI);
        res.chroma_valid = 1'b1;
      end
    end
    left_rgb = {px.red, px.green, px.blue};

    // positions are only compared at row and frame end, never bounds-checked
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        res.frame_end = 1'b1;
      end else begin
        row_pos = (row_pos + 1) & 32'hFFF;
      end
    end else begin
      col_pos = (col_pos + 1) & 32'hFFF;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Channel value biased toward the rails.
  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic r2n_in_t rand_pixel();
    r2n_in_t px;
    px.red = rand_channel();
    px.green = rand_channel();
    px.blue = rand_channel();
    px.frame_start = 1'b0;
    return px;
  endfunction

  // One input transaction. in_push stays high afterwards so a following call
  // can stream back to back; drain_pipeline drops it.
  task automatic push_pixel(input r2n_in_t px);
    int gap;
    int unsigned idx;
    // An odd-row read of a line entry that no even row ever wrote is outside
    // the contract; restart the frame instead of causing one.
    idx = col_pos >> 1;
    if (idx >= LINE_DEPTH) idx = LINE_DEPTH - 1;
    if (!px.frame_start && col_pos[0] && row_pos[0] && !pair_written[idx])
      px.frame_start = 1'b1;

    gap = 0;
    if (!calm && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 3);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_full);
    pending_pixels.push_back(convert_pixel(px));
    pixels_sent++;
  endtask

  // Random pixels; the first may open a frame, the rest carry stray frame
  // starts at noise_pct percent.
  task automatic stream_pixels(input int count, input bit open_frame, input int noise_pct);
    r2n_in_t px;
    for (int i = 0; i < count; i++) begin
      px = rand_pixel();
      px.frame_start = (i == 0) ? open_frame : ($urandom_range(0, 99) < noise_pct);
      push_pixel(px);
    end
  endtask

  // Stop offering, let every expected transaction come out, then wait a margin
  // more so the block is idle for a register write.
  task automatic drain_pipeline();
    in_push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input r2n_reg_t idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= SIZE_W'(value);
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) frame_width_q = SIZE_W'(value);
    else frame_height_q = SIZE_W'(value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(input int width, input int height);
    drain_pipeline();
    write_reg(REG_FRAME_WIDTH, width);
    write_reg(REG_FRAME_HEIGHT, height);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Saturated colors per 2x2 block: red and blue push Cr and Cb to the top
  // clamp, cyan and yellow push them to the bottom clamp.
  task automatic test_color_extremes();
    r2n_in_t px;
    set_size(4, 2);
    for (int i = 0; i < 8; i++) begin
      px = '0;
      if (i % 4 < 2) px.red = 8'hFF;
      else px.blue = 8'hFF;
      px.frame_start = (i == 0);
      push_pixel(px);
    end
    for (int i = 0; i < 8; i++) begin
      px = (i % 4 < 2) ? {8'h00, 8'hFF, 8'hFF, 1'b0} : {8'hFF, 8'hFF, 8'h00, 1'b0};
      px.frame_start = (i == 0);
      push_pixel(px);
    end
  endtask

  // 3x3 black/white checkerboard: luma at both rails, last row and column
  // give no chroma. Then 0x0, which acts as a 1x1 frame.
  task automatic test_odd_and_zero_sizes();
    r2n_in_t px;
    set_size(3, 3);
    for (int i = 0; i < 9; i++) begin
      px = (i % 2) ? {8'hFF, 8'hFF, 8'hFF, 1'b0} : '0;
      px.frame_start = (i == 0);
      push_pixel(px);
    end
    set_size(0, 0);
    stream_pixels(2, 1'b1, 0);
  endtask

  // Width shrinks and height changes in the middle of a frame, then a frame
  // start arrives mid-row.
  task automatic test_size_change_mid_frame();
    r2n_in_t px;
    set_size(6, 4);
    stream_pixels(9, 1'b1, 0);
    drain_pipeline();
    write_reg(REG_FRAME_WIDTH, 4);
    stream_pixels(6, 1'b0, 0);
    drain_pipeline();
    write_reg(REG_FRAME_HEIGHT, 3);
    stream_pixels(5, 1'b0, 0);
    px = rand_pixel();
    px.frame_start = 1'b1;
    push_pixel(px);
    stream_pixels(4, 1'b0, 0);
  endtask

  // All-ones and zero register values: short runs into oversize frames, a
  // one-pixel-wide frame, and a zero height that closes a frame every pixel.
  task automatic test_largest_sizes();
    set_size((1 << SIZE_W) - 1, 2);
    stream_pixels(16, 1'b1, 0);
    set_size(0, (1 << SIZE_W) - 1);
    stream_pixels(8, 1'b1, 0);
    set_size(1, 0);
    stream_pixels(4, 1'b1, 0);
  endtask

  // Mostly whole frames of random small sizes, some truncated, some without
  // an opening frame start, with stray frame starts as noise.
  task automatic test_random_frames(input int target);
    int unsigned first;
    int w;
    int h;
    int count;
    first = pixels_sent;
    while (pixels_sent - first < target) begin
      if (pixels_sent == first || $urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 9) == 0) begin
          w = $urandom_range(13, 80);
          h = $urandom_range(1, 4);
        end else begin
          w = $urandom_range(1, 10);
          h = $urandom_range(1, 6);
        end
        set_size(w, h);
      end
      count = w * h;
      if ($urandom_range(0, 7) == 0) count = $urandom_range(1, count);
      stream_pixels(count, $urandom_range(0, 7) != 0, 3);
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the block fills up and asserts in_full.
  task automatic test_output_backpressure();
    set_size(8, 4);
    calm = 1'b1;
    hold_req = 1'b1;
    stream_pixels(64, 1'b1, 0);
    calm = 1'b0;
  endtask

  // Long stretch at full rate on both sides.
  task automatic test_back_to_back();
    calm = 1'b1;
    set_size(6, 4);
    stream_pixels(96, 1'b1, 2);
    drain_pipeline();
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random pops, a calm mode, and the counted hold-off
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= calm || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("[%0t] ERROR: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("transaction %0d: %s is %0d, expected %0d",
                                results_checked, name, got, want));
  endtask

  // Sampled at the edge, before the DUT's own updates land.
  always @(posedge clk) begin : result_check
    r2n_out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("transaction %0d arrived with nothing expected",
                                  results_checked));
      end else begin
        want = pending_pixels.pop_front();
        check_field("luma", out_data.luma, want.luma);
        check_field("chroma_valid", out_data.chroma_valid, want.chroma_valid);
        check_field("cb", out_data.cb, want.cb);
        check_field("cr", out_data.cr, want.cr);
        check_field("frame_end", out_data.frame_end, want.frame_end);
        if (want.chroma_valid) chroma_blocks++;
        if (want.frame_end) frames_closed++;
      end
      results_checked++;
    end
  end

  // Watchdog: any transaction or register write counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] ERROR: no progress for %0d cycles, %0d transactions outstanding",
                 $time, WATCHDOG_LIMIT, pending_pixels.size());
        $display("rgb_to_nv12_converter_unit: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_color_extremes();
    test_odd_and_zero_sizes();
    test_size_change_mid_frame();
    test_largest_sizes();
    test_random_frames(190);
    test_output_backpressure();
    test_back_to_back();

    drain_pipeline();
    $display("Checked %0d pixels: %0d chroma blocks, %0d frame ends, %0d errors.",
             results_checked, chroma_blocks, frames_closed, mismatch_count);
    $display("Sizes 0 to 8191 each way, mid-frame resizing, a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (mismatch_count == 0)
      $display("rgb_to_nv12_converter_unit: match");
    else
      $display("rgb_to_nv12_converter_unit: mismatch");
    $finish;
  end

endmodule
